[design/jev_pkg.sv]
package jev_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 36;   // CORDIC datapath width
    localparam int PW           = 34;   // rounded product width
    localparam int MUL_STEPS    = 24;

    localparam logic signed [CW-1:0] GAIN_INV    = CW'(652032874);
    localparam logic signed [CW-1:0] QUARTER_PI  = CW'(32'h2000_0000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PREP,
        ST_VEC,
        ST_HALVE,
        ST_ROT,
        ST_MUL,
        ST_COMMIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PAIR_01,
        PAIR_02,
        PAIR_12
    } t_pair;

    typedef struct packed {
        logic                 start;
        logic                 vect;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic_cmd;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic_res;

    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [CW-1:0] r;
        unique case (idx)
            5'd0:  r = CW'(32'h2000_0000);
            5'd1:  r = CW'(32'h12E4_051D);
            5'd2:  r = CW'(32'h09FB_385B);
            5'd3:  r = CW'(32'h0511_11D4);
            5'd4:  r = CW'(32'h028B_0D43);
            5'd5:  r = CW'(32'h0145_D7E1);
            5'd6:  r = CW'(32'h00A2_F61E);
            5'd7:  r = CW'(32'h0051_7C55);
            5'd8:  r = CW'(32'h0028_BE53);
            5'd9:  r = CW'(32'h0014_5F2E);
            5'd10: r = CW'(32'h000A_2F98);
            5'd11: r = CW'(32'h0005_17CC);
            5'd12: r = CW'(32'h0002_8BE6);
            5'd13: r = CW'(32'h0001_45F3);
            5'd14: r = CW'(32'h0000_A2F9);
            5'd15: r = CW'(32'h0000_517C);
            5'd16: r = CW'(32'h0000_28BE);
            5'd17: r = CW'(32'h0000_145F);
            5'd18: r = CW'(32'h0000_0A2F);
            5'd19: r = CW'(32'h0000_0517);
            5'd20: r = CW'(32'h0000_028B);
            5'd21: r = CW'(32'h0000_0145);
            5'd22: r = CW'(32'h0000_00A2);
            5'd23: r = CW'(32'h0000_0051);
            5'd24: r = CW'(32'h0000_0028);
            5'd25: r = CW'(32'h0000_0014);
            5'd26: r = CW'(32'h0000_000A);
            5'd27: r = CW'(32'h0000_0005);
            5'd28: r = CW'(32'h0000_0002);
            5'd29: r = CW'(32'h0000_0001);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/jev_cordic.sv]
module jev_cordic
    import jev_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_cmd i_cmd,
    output t_cordic_res o_res
);

    logic                 r_busy, r_done, r_vect;
    logic [4:0]           r_step;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] xs, ys, ang;
    logic                 sigma;

    assign xs    = r_x >>> r_step;
    assign ys    = r_y >>> r_step;
    assign ang   = atan_lut(r_step);
    // positive sense: x -= y>>i, y += x>>i, z -= atan
    assign sigma = r_vect ? r_y[CW-1] : ~r_z[CW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_cmd.start && (r_step == 5'(CORDIC_STEPS - 1));
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vect <= i_cmd.vect;
            r_x    <= i_cmd.x;
            r_y    <= i_cmd.y;
            r_z    <= i_cmd.z;
        end else if (r_busy) begin
            if (sigma) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.x    = r_x;
    assign o_res.y    = r_y;
    assign o_res.z    = r_z;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("cordic done without a run");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.start)
        else $error("cordic restarted while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step < 5'(CORDIC_STEPS)))
        else $error("cordic step out of range");
`endif

endmodule

[design/jacobi_eigen_3x3_unit.sv]
// Per rotation: search, prep, atan (30 CORDIC steps, then done), halve, sincos,
//   multiply (24 products through one shared 32x32 multiplier) and commit; diagonal
//   entries within tolerance of each other skip atan and halve.
//   Up to ROTATION_LIMIT+1 rotations, a final search, then 3 result beats.
// Throughput: one matrix at a time; the input is not ready until the third
//   result beat has been taken. Reset: synchronous active low; tolerance back to 1.
module jacobi_eigen_3x3_unit
    import jev_pkg::*;
#(
    parameter int ROTATION_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_cov_xx,
    input  logic [31:0] i_cov_yy,
    input  logic [31:0] i_cov_zz,
    input  logic [31:0] i_cov_xy,
    input  logic [31:0] i_cov_xz,
    input  logic [31:0] i_cov_yz,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_eigen_value,
    output logic [31:0] o_vec_x,
    output logic [31:0] o_vec_y,
    output logic [31:0] o_vec_z,
    output logic        o_converged,
    output logic        o_last_pair
);

    localparam int CNTW = $clog2(ROTATION_LIMIT + 2);

    t_state r_state, n_state;
    t_pair  r_pair;

    logic [15:0]        r_tol;
    logic [CNTW-1:0]    r_count;
    logic [4:0]         r_mstep;
    logic               r_phase;
    logic [1:0]         r_oidx;
    logic               r_conv;

    logic signed [31:0] r_a00, r_a11, r_a22, r_a01, r_a02, r_a12;
    logic signed [31:0] r_v [3][3];
    logic signed [31:0] r_aii, r_ajj, r_aij, r_aki, r_akj;
    logic signed [31:0] r_xi [3];
    logic signed [31:0] r_xj [3];
    logic signed [31:0] r_c, r_s;
    logic signed [63:0] r_prod;
    logic signed [PW-1:0] r_pr [MUL_STEPS];

    t_cordic_cmd cmd;
    t_cordic_res res;

    jev_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    // pivot search
    logic [32:0] abs01, abs02, abs12, amax;
    t_pair       pick;
    assign abs01 = r_a01[31] ? -{r_a01[31], r_a01} : {1'b0, r_a01};
    assign abs02 = r_a02[31] ? -{r_a02[31], r_a02} : {1'b0, r_a02};
    assign abs12 = r_a12[31] ? -{r_a12[31], r_a12} : {1'b0, r_a12};

    always_comb begin
        amax = '0;
        pick = PAIR_01;
        if (abs01 > amax) begin
            amax = abs01;
            pick = PAIR_01;
        end
        if (abs02 > amax) begin
            amax = abs02;
            pick = PAIR_02;
        end
        if (abs12 > amax) begin
            amax = abs12;
            pick = PAIR_12;
        end
    end

    logic search_done, budget_out;
    assign budget_out  = r_count > CNTW'(ROTATION_LIMIT);
    assign search_done = amax <= {17'd0, r_tol};

    // angle setup
    logic signed [32:0] d;
    logic [32:0]        absd;
    logic               diag_eq;
    logic signed [CW-1:0] vy, th;
    assign d       = 33'(r_aii) - 33'(r_ajj);
    assign absd    = d[32] ? -d : d;
    assign diag_eq = absd <= {17'd0, r_tol};
    assign vy      = d[32] ? -(CW'(r_aij) <<< 1) : (CW'(r_aij) <<< 1);
    // halve toward zero
    assign th      = (res.z + $signed(CW'(res.z[CW-1]))) >>> 1;

    // shared multiplier operands
    logic signed [31:0] opa, opb;
    always_comb begin
        opa = r_c;
        opb = r_c;
        unique case (r_mstep)
            5'd0:  begin opa = r_c;              opb = r_c;   end
            5'd1:  begin opa = r_s;              opb = r_s;   end
            5'd2:  begin opa = r_c;              opb = r_s;   end
            5'd3:  begin opa = r_pr[2][31:0];    opb = r_aij; end
            5'd4:  begin opa = r_pr[0][31:0];    opb = r_aii; end
            5'd5:  begin opa = r_pr[1][31:0];    opb = r_ajj; end
            5'd6:  begin opa = r_pr[1][31:0];    opb = r_aii; end
            5'd7:  begin opa = r_pr[0][31:0];    opb = r_ajj; end
            5'd8:  begin opa = r_c;              opb = r_aki; end
            5'd9:  begin opa = r_s;              opb = r_akj; end
            5'd10: begin opa = r_c;              opb = r_akj; end
            5'd11: begin opa = r_s;              opb = r_aki; end
            5'd12: begin opa = r_c;              opb = r_xi[0]; end
            5'd13: begin opa = r_s;              opb = r_xj[0]; end
            5'd14: begin opa = r_c;              opb = r_xj[0]; end
            5'd15: begin opa = r_s;              opb = r_xi[0]; end
            5'd16: begin opa = r_c;              opb = r_xi[1]; end
            5'd17: begin opa = r_s;              opb = r_xj[1]; end
            5'd18: begin opa = r_c;              opb = r_xj[1]; end
            5'd19: begin opa = r_s;              opb = r_xi[1]; end
            5'd20: begin opa = r_c;              opb = r_xi[2]; end
            5'd21: begin opa = r_s;              opb = r_xj[2]; end
            5'd22: begin opa = r_c;              opb = r_xj[2]; end
            5'd23: begin opa = r_s;              opb = r_xi[2]; end
            default: begin opa = r_c;            opb = r_c;   end
        endcase
    end

    logic signed [63:0] prod_rnd;
    assign prod_rnd = r_prod + 64'sd536870912;

    // rotation results
    logic signed [31:0] app, aqq, akp, akq;
    logic signed [31:0] vp [3];
    logic signed [31:0] vq [3];
    always_comb begin
        app = sat32(37'(r_pr[4]) + (37'(r_pr[3]) <<< 1) + 37'(r_pr[5]));
        aqq = sat32(37'(r_pr[6]) - (37'(r_pr[3]) <<< 1) + 37'(r_pr[7]));
        akp = sat32(37'(r_pr[8]) + 37'(r_pr[9]));
        akq = sat32(37'(r_pr[10]) - 37'(r_pr[11]));
        for (int r = 0; r < 3; r++) begin
            vp[r] = sat32(37'(r_pr[12 + 4*r]) + 37'(r_pr[13 + 4*r]));
            vq[r] = sat32(37'(r_pr[14 + 4*r]) - 37'(r_pr[15 + 4*r]));
        end
    end

    // next state and CORDIC command
    always_comb begin
        n_state   = r_state;
        cmd.start = 1'b0;
        cmd.vect  = 1'b1;
        cmd.x     = CW'({1'b0, absd});
        cmd.y     = vy;
        cmd.z     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (budget_out || search_done) n_state = ST_OUT;
                else n_state = ST_PREP;
            end
            ST_PREP: begin
                cmd.start = 1'b1;
                if (diag_eq) begin
                    cmd.vect = 1'b0;
                    cmd.x    = GAIN_INV;
                    cmd.y    = '0;
                    cmd.z    = r_aij[31] ? -QUARTER_PI : QUARTER_PI;
                    n_state  = ST_ROT;
                end else begin
                    n_state  = ST_VEC;
                end
            end
            ST_VEC: begin
                if (res.done) n_state = ST_HALVE;
            end
            ST_HALVE: begin
                cmd.start = 1'b1;
                cmd.vect  = 1'b0;
                cmd.x     = GAIN_INV;
                cmd.y     = '0;
                cmd.z     = th;
                n_state   = ST_ROT;
            end
            ST_ROT: begin
                if (res.done) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_phase && r_mstep == 5'(MUL_STEPS - 1)) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                n_state = ST_SEARCH;
            end
            ST_OUT: begin
                if (i_ready && r_oidx == 2'd2) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= 16'd1;
            r_count <= '0;
            r_mstep <= '0;
            r_phase <= 1'b0;
            r_oidx  <= '0;
            r_conv  <= 1'b0;
            r_pair  <= PAIR_01;
        end else begin
            if (i_cfg_we) r_tol <= i_cfg_wdata;
            unique case (r_state)
                ST_IDLE: begin
                    r_count <= '0;
                end
                ST_SEARCH: begin
                    r_pair  <= pick;
                    r_oidx  <= '0;
                    r_conv  <= ~budget_out;
                    r_mstep <= '0;
                    r_phase <= 1'b0;
                end
                ST_MUL: begin
                    r_phase <= ~r_phase;
                    if (r_phase) r_mstep <= r_mstep + 5'd1;
                end
                ST_COMMIT: begin
                    r_count <= r_count + CNTW'(1);
                end
                ST_OUT: begin
                    if (i_ready) r_oidx <= r_oidx + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_a00 <= i_cov_xx;
                    r_a11 <= i_cov_yy;
                    r_a22 <= i_cov_zz;
                    r_a01 <= i_cov_xy;
                    r_a02 <= i_cov_xz;
                    r_a12 <= i_cov_yz;
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            r_v[r][c] <= (r == c) ? 32'sh4000_0000 : 32'sd0;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                unique case (pick)
                    PAIR_01: begin
                        r_aii <= r_a00; r_ajj <= r_a11; r_aij <= r_a01;
                        r_aki <= r_a02; r_akj <= r_a12;
                        for (int r = 0; r < 3; r++) begin
                            r_xi[r] <= r_v[r][0];
                            r_xj[r] <= r_v[r][1];
                        end
                    end
                    PAIR_02: begin
                        r_aii <= r_a00; r_ajj <= r_a22; r_aij <= r_a02;
                        r_aki <= r_a01; r_akj <= r_a12;
                        for (int r = 0; r < 3; r++) begin
                            r_xi[r] <= r_v[r][0];
                            r_xj[r] <= r_v[r][2];
                        end
                    end
                    default: begin
                        r_aii <= r_a11; r_ajj <= r_a22; r_aij <= r_a12;
                        r_aki <= r_a01; r_akj <= r_a02;
                        for (int r = 0; r < 3; r++) begin
                            r_xi[r] <= r_v[r][1];
                            r_xj[r] <= r_v[r][2];
                        end
                    end
                endcase
            end
            ST_ROT: begin
                if (res.done) begin
                    r_c <= res.x[31:0];
                    r_s <= res.y[31:0];
                end
            end
            ST_MUL: begin
                if (!r_phase) r_prod <= 64'(opa) * 64'(opb);
                else          r_pr[r_mstep] <= prod_rnd[63:30];
            end
            ST_COMMIT: begin
                unique case (r_pair)
                    PAIR_01: begin
                        r_a00 <= app; r_a11 <= aqq; r_a01 <= '0;
                        r_a02 <= akp; r_a12 <= akq;
                        for (int r = 0; r < 3; r++) begin
                            r_v[r][0] <= vp[r];
                            r_v[r][1] <= vq[r];
                        end
                    end
                    PAIR_02: begin
                        r_a00 <= app; r_a22 <= aqq; r_a02 <= '0;
                        r_a01 <= akp; r_a12 <= akq;
                        for (int r = 0; r < 3; r++) begin
                            r_v[r][0] <= vp[r];
                            r_v[r][2] <= vq[r];
                        end
                    end
                    default: begin
                        r_a11 <= app; r_a22 <= aqq; r_a12 <= '0;
                        r_a01 <= akp; r_a02 <= akq;
                        for (int r = 0; r < 3; r++) begin
                            r_v[r][1] <= vp[r];
                            r_v[r][2] <= vq[r];
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // result beats
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_converged = r_conv;
    assign o_last_pair = (r_oidx == 2'd2);

    always_comb begin
        unique case (r_oidx)
            2'd0: begin
                o_eigen_value = r_a00;
                o_vec_x = r_v[0][0]; o_vec_y = r_v[1][0]; o_vec_z = r_v[2][0];
            end
            2'd1: begin
                o_eigen_value = r_a11;
                o_vec_x = r_v[0][1]; o_vec_y = r_v[1][1]; o_vec_z = r_v[2][1];
            end
            default: begin
                o_eigen_value = r_a22;
                o_vec_x = r_v[0][2]; o_vec_y = r_v[1][2]; o_vec_z = r_v[2][2];
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cordic_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.busy |-> (r_state == ST_VEC || r_state == ST_ROT))
        else $error("cordic running outside a wait state");
    a_pivot_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && r_pair == PAIR_01) |=> (r_a01 == 32'sd0))
        else $error("pivot entry not cleared");
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(ROTATION_LIMIT + 1))
        else $error("rotation count past budget");
    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_oidx != 2'd3))
        else $error("result index out of range");
`endif

endmodule

[test/jacobi_eigen_3x3_checker.sv]
module jacobi_eigen_3x3_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_cov_xx,
    input  logic [31:0] i_cov_yy,
    input  logic [31:0] i_cov_zz,
    input  logic [31:0] i_cov_xy,
    input  logic [31:0] i_cov_xz,
    input  logic [31:0] i_cov_yz,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_eigen_value,
    input  logic [31:0] i_vec_x,
    input  logic [31:0] i_vec_y,
    input  logic [31:0] i_vec_z,
    input  logic        i_converged,
    input  logic        i_last_pair,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pairs_checked,
    output int          o_unconverged
);

    localparam int ROT_LIMIT = 64;
    localparam int N_STEPS   = 30;
    localparam longint Q30_UNIT   = 64'sd1 << 30;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint EIGHTH_REV = 64'sh2000_0000;
    localparam longint ANGLE_STEP [N_STEPS] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    typedef struct {
        logic [31:0] value;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        conv;
        logic        last;
    } t_eigen_pair;

    t_eigen_pair expected_pairs[$];
    longint      tol_now;

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint vector_angle(input longint x0, input longint y0);
        longint x, y, z, xs, ys;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys; y = y + xs; z = z - ANGLE_STEP[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ANGLE_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic void rotate_unit(input longint th0, output longint c,
                                        output longint s);
        longint x, y, th, xs, ys;
        x = GAIN_Q30;
        y = 0;
        th = th0;
        for (int i = 0; i < N_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (th >= 0) begin
                x = x - ys; y = y + xs; th = th - ANGLE_STEP[i];
            end else begin
                x = x + ys; y = y - xs; th = th + ANGLE_STEP[i];
            end
        end
        c = x;
        s = y;
    endfunction

    task automatic diagonalise(input logic [31:0] e [6]);
        longint m [3][3];
        longint v [3][3];
        longint amax, aii, ajj, aij, d, yv, th, c, s, c2, s2, cs, t, a1, a2;
        int p, q, rot;
        logic conv;
        t_eigen_pair pr;
        m[0][0] = longint'($signed(e[0]));
        m[1][1] = longint'($signed(e[1]));
        m[2][2] = longint'($signed(e[2]));
        m[0][1] = longint'($signed(e[3])); m[1][0] = m[0][1];
        m[0][2] = longint'($signed(e[4])); m[2][0] = m[0][2];
        m[1][2] = longint'($signed(e[5])); m[2][1] = m[1][2];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                v[i][j] = (i == j) ? Q30_UNIT : 0;
        conv = 1'b0;
        rot = 0;
        while (rot <= ROT_LIMIT) begin
            p = 0; q = 1; amax = 0;
            for (int i = 0; i < 2; i++)
                for (int j = i + 1; j < 3; j++)
                    if (mag(m[i][j]) > amax) begin
                        amax = mag(m[i][j]); p = i; q = j;
                    end
            if (amax <= tol_now) begin
                conv = 1'b1;
                break;
            end
            aii = m[p][p]; ajj = m[q][q]; aij = m[p][q];
            d = aii - ajj;
            if (mag(d) <= tol_now) begin
                th = aij < 0 ? -EIGHTH_REV : EIGHTH_REV;
            end else begin
                yv = 2 * aij;
                if (d < 0) begin
                    d = -d; yv = -yv;
                end
                th = vector_angle(d, yv) / 2;   // truncates toward zero
            end
            rotate_unit(th, c, s);
            c2 = mul_q30(c, c);
            s2 = mul_q30(s, s);
            cs = mul_q30(c, s);
            t = mul_q30(cs, aij);
            m[p][p] = clip32(mul_q30(c2, aii) + 2 * t + mul_q30(s2, ajj));
            m[q][q] = clip32(mul_q30(s2, aii) - 2 * t + mul_q30(c2, ajj));
            m[p][q] = 0; m[q][p] = 0;
            for (int k = 0; k < 3; k++) begin
                if (k != p && k != q) begin
                    a1 = m[k][p]; a2 = m[k][q];
                    m[k][p] = clip32(mul_q30(c, a1) + mul_q30(s, a2));
                    m[p][k] = m[k][p];
                    m[k][q] = clip32(mul_q30(c, a2) - mul_q30(s, a1));
                    m[q][k] = m[k][q];
                end
            end
            for (int k = 0; k < 3; k++) begin
                a1 = v[k][p]; a2 = v[k][q];
                v[k][p] = clip32(mul_q30(c, a1) + mul_q30(s, a2));
                v[k][q] = clip32(mul_q30(c, a2) - mul_q30(s, a1));
            end
            rot++;
        end
        if (!conv) o_unconverged++;
        for (int k = 0; k < 3; k++) begin
            pr.value = 32'(clip32(m[k][k]));
            pr.vx = 32'(v[0][k]);
            pr.vy = 32'(v[1][k]);
            pr.vz = 32'(v[2][k]);
            pr.conv = conv;
            pr.last = (k == 2);
            expected_pairs.push_back(pr);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v,
                     act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [31:0] ent [6];
        t_eigen_pair want;
        if (!i_rst_n) begin
            tol_now = 1;
            o_fail_count = 0;
            o_pairs_checked = 0;
            o_unconverged = 0;
        end else begin
            if (i_cfg_we) tol_now = longint'(i_cfg_wdata);
            if (i_valid && i_ready_in) begin
                ent = '{i_cov_xx, i_cov_yy, i_cov_zz, i_cov_xy, i_cov_xz, i_cov_yz};
                diagonalise(ent);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t: result beat with nothing expected, value %h",
                             $time, i_eigen_value);
                    o_fail_count++;
                end else begin
                    want = expected_pairs.pop_front();
                    compare_field("eigen_value", want.value, i_eigen_value);
                    compare_field("vec_x", want.vx, i_vec_x);
                    compare_field("vec_y", want.vy, i_vec_y);
                    compare_field("vec_z", want.vz, i_vec_z);
                    compare_field("converged", 32'(want.conv), 32'(i_converged));
                    compare_field("last_pair", 32'(want.last), 32'(i_last_pair));
                    o_pairs_checked++;
                end
            end
        end
        o_pending = expected_pairs.size();
    end

endmodule

[test/tb_jacobi_eigen_3x3_unit.sv]
module tb_jacobi_eigen_3x3_unit;

    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_cov_xx, i_cov_yy, i_cov_zz, i_cov_xy, i_cov_xz, i_cov_yz;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_eigen_value, o_vec_x, o_vec_y, o_vec_z;
    logic        o_converged, o_last_pair;

    int     fail_count, pending, pairs_checked, unconverged;
    int     matrices_sent;
    int     burst_left;
    longint cycle_no;
    int     stall_mode;

    jacobi_eigen_3x3_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cov_xx(i_cov_xx), .i_cov_yy(i_cov_yy), .i_cov_zz(i_cov_zz),
        .i_cov_xy(i_cov_xy), .i_cov_xz(i_cov_xz), .i_cov_yz(i_cov_yz),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_eigen_value(o_eigen_value), .o_vec_x(o_vec_x), .o_vec_y(o_vec_y),
        .o_vec_z(o_vec_z), .o_converged(o_converged), .o_last_pair(o_last_pair)
    );

    jacobi_eigen_3x3_checker eigen_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_cov_xx(i_cov_xx), .i_cov_yy(i_cov_yy), .i_cov_zz(i_cov_zz),
        .i_cov_xy(i_cov_xy), .i_cov_xz(i_cov_xz), .i_cov_yz(i_cov_yz),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_eigen_value(o_eigen_value), .i_vec_x(o_vec_x), .i_vec_y(o_vec_y),
        .i_vec_z(o_vec_z), .i_converged(o_converged), .i_last_pair(o_last_pair),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_pairs_checked(pairs_checked), .o_unconverged(unconverged)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("timeout with %0d result beats outstanding", pending);
            $display("tb_jacobi_eigen_3x3_unit NOT OK");
            $finish;
        end
    end

    // receiver: stall style is picked at random and changes over the run
    always @(posedge i_clk) begin
        if (cycle_no % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= (cycle_no % 7 < 2);
            default: i_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_matrix(input logic [31:0] xx, yy, zz, xy, xz, yz);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 30);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 6);
        end
        i_valid  <= 1'b1;
        i_cov_xx <= xx; i_cov_yy <= yy; i_cov_zz <= zz;
        i_cov_xy <= xy; i_cov_xz <= xz; i_cov_yz <= yz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        matrices_sent++;
    endtask

    task automatic drain_and_set_tolerance(input logic [15:0] tol);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        burst_left = 0;
    endtask

    // mostly moderate magnitudes, sometimes the full 32-bit range
    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
            2: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
            default: return 32'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [31:0] d;
        for (int n = 0; n < count; n++) begin
            d = rand_entry();
            if ($urandom_range(0, 7) == 0)
                // two equal diagonal entries and a tied pivot
                send_matrix(d, d, rand_entry(), d ^ 32'h1, d ^ 32'h1, rand_entry());
            else
                send_matrix(rand_entry(), rand_entry(), rand_entry(),
                            rand_entry(), rand_entry(), rand_entry());
        end
    endtask

    initial begin
        cycle_no    = 0;
        stall_mode  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        {i_cov_xx, i_cov_yy, i_cov_zz, i_cov_xy, i_cov_xz, i_cov_yz} = '0;
        matrices_sent = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset tolerance
        send_matrix(0, 0, 0, 0, 0, 0);
        send_matrix(32'h10000, 32'h20000, 32'h30000, 0, 0, 0);
        send_matrix(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_matrix(32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000);
        send_matrix(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 1);
        send_matrix(32'h10000, 32'h10000, 0, 32'h8000, 0, 0);
        send_matrix(32'h10000, 32'h10000, 0, 32'hFFFF8000, 0, 0);
        send_matrix(32'h10000, 32'h10000, 32'h10000, 32'h4000, 32'h4000, 32'h4000);
        send_matrix(0, 0, 0, 32'hFFFFC000, 32'h4000, 32'hFFFFC000);
        send_matrix(32'h20000, 32'h10001, 32'h30000, 1, 1, 1);
        send_matrix(32'h20000, 32'h10000, 32'h30000, 2, 0, 0);
        send_matrix(32'hFFFE0000, 32'h50000, 32'h0, 0, 32'h12345, 0);
        send_matrix(32'h40000000, 32'hC0000000, 32'h0, 32'h0, 0, 32'h60000000);
        send_matrix(32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                    32'h33333333);
        send_random(60);

        drain_and_set_tolerance(16'd0);
        send_matrix(32'h10000, 32'h10000, 0, 32'h8000, 0, 0);
        send_matrix(32'h20000, 32'h10000, 32'h30000, 1, 0, 0);
        send_random(25);

        drain_and_set_tolerance(16'hFFFF);
        send_matrix(32'h10000, 32'h1FFFF, 0, 32'hFFFF, 32'h10000, 0);
        send_random(100);

        drain_and_set_tolerance(16'($urandom_range(2, 16'hFFFE)));
        send_random(100);

        drain_and_set_tolerance(16'($urandom_range(2, 255)));
        send_random(80);

        drain_and_set_tolerance(16'd1);
        send_random(75);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d matrices over six tolerance settings, %0d eigenpairs checked",
                 matrices_sent, pairs_checked);
        $display("%0d matrices ran out of rotations", unconverged);
        if (fail_count == 0) begin
            $display("tb_jacobi_eigen_3x3_unit OK");
        end else begin
            $display("tb_jacobi_eigen_3x3_unit NOT OK");
        end
        $finish;
    end

endmodule
